>>> src/fact_pkg.sv
// ----------------------------------------------------------------------------
// fact_pkg
// Shared constants, CORDIC angle table and pipeline payload types for the
// field-aligned coordinate transform.
// ----------------------------------------------------------------------------
package fact_pkg;

  localparam int FRAC_BITS    = 16;
  localparam int CORDIC_STEPS = 24;
  localparam int QBITS        = 32;            // quotient bits out of the divider
  localparam int DVD_W        = 64 + QBITS;    // dividend width
  localparam int CW           = 44;            // CORDIC x/y width
  localparam int ZW           = 36;            // CORDIC angle width
  localparam int NORM_BITS    = 40;            // vectoring inputs kept below 2^40
  localparam int ONE_EXP      = 32 + FRAC_BITS;
  localparam int SH_MIN       = ONE_EXP - NORM_BITS + 1;
  localparam int ROT_X_EXP    = 30;

  localparam logic [31:0] HOMOG_LIMIT = 32'd42950;
  localparam logic [31:0] GRID_RESET  = 32'd1 << FRAC_BITS;
  localparam logic [32:0] PI_2_Q32    = 33'd6746518852;
  localparam logic [63:0] ROUND_HALF  = 64'd1 << (FRAC_BITS - 1);
  localparam logic [95:0] TAN_LIMIT   = 96'(PI_2_Q32) << (2 * FRAC_BITS);
  localparam logic [95:0] TAN_ZERO    = 96'd1 << (2 * FRAC_BITS);
  localparam logic [32:0] MAG_NEG_MAX = 33'h080000000;
  localparam logic [32:0] MAG_POS_MAX = 33'h07FFFFFFF;
  localparam logic [31:0] SAT_POS     = 32'h7FFFFFFF;
  localparam logic [31:0] SAT_NEG     = 32'h80000000;

  // atan(2^-i) in Q32
  localparam logic [31:0] ATAN_Q32 [32] = '{
    32'd3373259426, 32'd1991351318, 32'd1052175346, 32'd534100635,
    32'd268086748,  32'd134174063,  32'd67103403,   32'd33553749,
    32'd16777131,   32'd8388597,    32'd4194303,    32'd2097152,
    32'd1048576,    32'd524288,     32'd262144,     32'd131072,
    32'd65536,      32'd32768,      32'd16384,      32'd8192,
    32'd4096,       32'd2048,       32'd1024,       32'd512,
    32'd256,        32'd128,        32'd64,         32'd32,
    32'd16,         32'd8,          32'd4,          32'd2
  };

  typedef enum logic [1:0] {
    KIND_DIRECT,   // result already known, no division
    KIND_HDIV,     // homogeneous x / D1
    KIND_ATAN,     // atan(xi*x) / (xi*D1)
    KIND_TAN       // tan(xi*D1*q) / xi
  } fact_kind_e;

  typedef enum logic {
    REG_CURVATURE  = 1'b0,
    REG_GRID_SCALE = 1'b1
  } fact_reg_e;

  typedef struct packed {
    fact_kind_e  kind;
    logic        neg;
    logic        sat;
    logic [31:0] mag;
  } fact_tag_t;

  typedef struct packed {
    logic                 rot;
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [ZW-1:0] z;
  } fact_cord_t;

  typedef struct packed {
    logic [63:0]      rem;
    logic [QBITS-1:0] low;
    logic [QBITS-1:0] quo;
    logic [63:0]      den;
    logic             neg;
    logic             sat;
    logic             bypass;
  } fact_div_t;

endpackage

>>> src/field_aligned_coord_transform.sv
// ----------------------------------------------------------------------------
// field_aligned_coord_transform
// Converts a Q16.16 position between Cartesian x and curvilinear q1.
// ----------------------------------------------------------------------------
// Takes one beat every clock cycle while the result side does not stall and
// returns the results in order. Each beat passes through the four input
// stages (magnitude, multipliers, product sum and normalise, CORDIC setup),
// the CORDIC_STEPS-stage CORDIC, two divider setup stages, the 32-stage
// restoring divider and the output register. A stall on the result side
// holds the whole pipe and shows on in_stall_o in the same cycle. Register
// writes take effect for beats accepted from the cycle after the write.
module field_aligned_coord_transform import fact_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [31:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        op_i,
  input  logic signed [31:0] position_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic signed [31:0] converted_o,
  output logic        range_error_o
);

  logic [31:0] curvature_q, grid_scale_q;
  logic [63:0] cprod_q;
  logic        homog;
  logic        adv;

  assign homog      = curvature_q < HOMOG_LIMIT;
  assign adv        = !(out_valid_o && out_stall_i);
  assign in_stall_o = !adv;

  // configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      curvature_q  <= '0;
      grid_scale_q <= GRID_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_CURVATURE:  curvature_q  <= cfg_wdata_i;
        REG_GRID_SCALE: grid_scale_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    cprod_q <= curvature_q * grid_scale_q;
  end

  // stage 1: sign and magnitude
  logic        s1_v_q, s1_op_q, s1_neg_q;
  logic [31:0] s1_mag_q;
  logic [31:0] pos_u;

  assign pos_u = unsigned'(position_i);

  // stage 2: multipliers
  logic        s2_v_q, s2_op_q, s2_neg_q;
  logic [31:0] s2_mag_q;
  logic [63:0] s2_mul0_q, s2_mlo_q, s2_mhi_q;
  logic [31:0] mul0_sel;

  assign mul0_sel = (s1_op_q && homog) ? grid_scale_q : curvature_q;

  // stage 3: product sum, rounding, leading one
  logic        s3_v_q, s3_neg_q;
  fact_kind_e  s3_kind_q;
  logic [31:0] s3_mag_q;
  logic [95:0] s3_prod_q;
  logic [63:0] s3_hr_q, s3_p_q;
  logic [5:0]  s3_sh_q;
  logic [6:0]  bl;
  logic [5:0]  sh_d;
  fact_kind_e  kind_d;

  always_comb begin
    bl = '0;
    for (int i = 0; i < 64; i++) begin
      if (s2_mul0_q[i]) bl = 7'(i + 1);
    end
  end

  always_comb begin
    if (int'(bl) - NORM_BITS > SH_MIN) sh_d = 6'(int'(bl) - NORM_BITS);
    else                               sh_d = 6'(SH_MIN);
    if (homog) kind_d = s2_op_q ? KIND_DIRECT : KIND_HDIV;
    else       kind_d = s2_op_q ? KIND_TAN : KIND_ATAN;
  end

  // stage 4: CORDIC setup
  logic       s4_v_q;
  fact_cord_t s4_cord_q, cord_d;
  fact_tag_t  s4_tag_q, tag_d;

  always_comb begin
    tag_d.kind = s3_kind_q;
    tag_d.neg  = s3_neg_q;
    tag_d.sat  = 1'b0;
    tag_d.mag  = s3_mag_q;
    cord_d.rot = 1'b0;
    cord_d.x   = CW'(1) << (ONE_EXP - int'(s3_sh_q));
    cord_d.y   = CW'(s3_p_q >> s3_sh_q);
    cord_d.z   = '0;
    unique case (s3_kind_q)
      KIND_DIRECT: begin
        tag_d.sat = |s3_hr_q[63:32];
        tag_d.mag = s3_hr_q[31:0];
      end
      KIND_HDIV: ;
      KIND_ATAN: begin
        if (s3_p_q == '0) begin
          tag_d.kind = KIND_DIRECT;
          tag_d.mag  = '0;
        end
      end
      KIND_TAN: begin
        cord_d.rot = 1'b1;
        cord_d.x   = CW'(1) << ROT_X_EXP;
        cord_d.y   = '0;
        cord_d.z   = ZW'(s3_prod_q >> (2 * FRAC_BITS));
        if (s3_prod_q >= TAN_LIMIT) begin
          // angle at or past pi/2
          tag_d.kind = KIND_DIRECT;
          tag_d.sat  = 1'b1;
        end else if (s3_prod_q < TAN_ZERO) begin
          tag_d.kind = KIND_DIRECT;
          tag_d.mag  = '0;
        end
      end
      default: ;
    endcase
  end

  // CORDIC
  logic       c_v;
  fact_cord_t c_cord;
  fact_tag_t  c_tag;

  fact_cordic u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (s4_v_q),
    .cord_i  (s4_cord_q),
    .tag_i   (s4_tag_q),
    .valid_o (c_v),
    .cord_o  (c_cord),
    .tag_o   (c_tag)
  );

  // stage 5: dividend and divisor
  logic             s5_v_q, s5_neg_q, s5_sat_q, s5_byp_q;
  logic [63:0]      s5_hi_q, s5_den_q;
  logic [QBITS-1:0] s5_lo_q, s5_quo_q;
  logic signed [CW-1:0] xv, yv;
  logic signed [ZW-1:0] zv;
  logic [32:0]      zc;
  logic [30:0]      yc;
  logic [63:0]      tan_den, den_d;
  logic [DVD_W-1:0] dvd;
  logic             sat_d, byp_d;
  logic [QBITS-1:0] quo_d;

  assign xv      = c_cord.x;
  assign yv      = c_cord.y;
  assign zv      = c_cord.z;
  assign tan_den = xv[31:0] * curvature_q;

  always_comb begin
    if (zv < 0)                                          zc = '0;
    else if (zv > $signed({{(ZW-33){1'b0}}, PI_2_Q32})) zc = PI_2_Q32;
    else                                                 zc = zv[32:0];
    yc    = (yv < 0) ? '0 : yv[30:0];
    dvd   = '0;
    den_d = cprod_q;
    sat_d = c_tag.sat;
    byp_d = 1'b0;
    quo_d = '0;
    unique case (c_tag.kind)
      KIND_DIRECT: begin
        byp_d = 1'b1;
        quo_d = c_tag.mag;
      end
      KIND_HDIV: begin
        dvd   = DVD_W'(c_tag.mag) << FRAC_BITS;
        den_d = 64'(grid_scale_q);
      end
      KIND_ATAN: begin
        dvd   = DVD_W'(zc) << (2 * FRAC_BITS);
      end
      KIND_TAN: begin
        dvd   = DVD_W'(yc) << (32 + FRAC_BITS);
        den_d = tan_den;
        if (xv <= 0) begin
          // cosine collapsed near pi/2
          sat_d = 1'b1;
          byp_d = 1'b1;
        end
      end
      default: ;
    endcase
  end

  // stage 6: zero and overflow screen
  logic      s6_v_q;
  fact_div_t s6_div_q, div_d;

  always_comb begin
    div_d.rem    = s5_hi_q;
    div_d.low    = s5_lo_q;
    div_d.quo    = s5_quo_q;
    div_d.den    = s5_den_q;
    div_d.neg    = s5_neg_q;
    div_d.sat    = s5_sat_q;
    div_d.bypass = s5_byp_q;
    if (!s5_byp_q) begin
      if (s5_hi_q == '0 && s5_lo_q == '0) begin
        div_d.bypass = 1'b1;
        div_d.quo    = '0;
      end else if (s5_hi_q >= s5_den_q) begin
        // quotient would not fit in QBITS (also a zero divisor)
        div_d.sat    = 1'b1;
        div_d.bypass = 1'b1;
      end
    end
  end

  logic      d_v;
  fact_div_t d_q;

  fact_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (s6_v_q),
    .div_i   (s6_div_q),
    .valid_o (d_v),
    .div_o   (d_q)
  );

  // output: round, saturate, apply sign
  logic        out_valid_q, range_error_q;
  logic [31:0] converted_q, conv_d;
  logic        rnd, ovf, flag_d;
  logic [32:0] q33;

  always_comb begin
    rnd    = !d_q.bypass && ({d_q.rem, 1'b0} >= {1'b0, d_q.den});
    q33    = {1'b0, d_q.quo} + 33'(rnd);
    ovf    = d_q.neg ? (q33 > MAG_NEG_MAX) : (q33 > MAG_POS_MAX);
    flag_d = d_q.sat || ovf;
    if (flag_d)        conv_d = d_q.neg ? SAT_NEG : SAT_POS;
    else if (d_q.neg)  conv_d = ~q33[31:0] + 32'd1;
    else               conv_d = q33[31:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q      <= 1'b0;
      s2_v_q      <= 1'b0;
      s3_v_q      <= 1'b0;
      s4_v_q      <= 1'b0;
      s5_v_q      <= 1'b0;
      s6_v_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (adv) begin
      s1_v_q      <= in_valid_i;
      s2_v_q      <= s1_v_q;
      s3_v_q      <= s2_v_q;
      s4_v_q      <= s3_v_q;
      s5_v_q      <= c_v;
      s6_v_q      <= s5_v_q;
      out_valid_q <= d_v;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_op_q       <= op_i;
      s1_neg_q      <= pos_u[31];
      s1_mag_q      <= pos_u[31] ? (~pos_u + 32'd1) : pos_u;

      s2_op_q       <= s1_op_q;
      s2_neg_q      <= s1_neg_q;
      s2_mag_q      <= s1_mag_q;
      s2_mul0_q     <= mul0_sel * s1_mag_q;
      s2_mlo_q      <= cprod_q[31:0] * s1_mag_q;
      s2_mhi_q      <= cprod_q[63:32] * s1_mag_q;

      s3_neg_q      <= s2_neg_q;
      s3_kind_q     <= kind_d;
      s3_mag_q      <= s2_mag_q;
      s3_prod_q     <= {s2_mhi_q, 32'd0} + {32'd0, s2_mlo_q};
      s3_hr_q       <= (s2_mul0_q + ROUND_HALF) >> FRAC_BITS;
      s3_p_q        <= s2_mul0_q;
      s3_sh_q       <= sh_d;

      s4_cord_q     <= cord_d;
      s4_tag_q      <= tag_d;

      s5_neg_q      <= c_tag.neg;
      s5_sat_q      <= sat_d;
      s5_byp_q      <= byp_d;
      s5_hi_q       <= dvd[DVD_W-1:QBITS];
      s5_lo_q       <= dvd[QBITS-1:0];
      s5_den_q      <= den_d;
      s5_quo_q      <= quo_d;

      s6_div_q      <= div_d;

      converted_q   <= conv_d;
      range_error_q <= flag_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign converted_o   = signed'(converted_q);
  assign range_error_o = range_error_q;

endmodule

>>> src/fact_cordic.sv
// ----------------------------------------------------------------------------
// fact_cordic
// Pipelined CORDIC, one micro-rotation per stage; vectoring or rotation mode
// chosen per beat.
// ----------------------------------------------------------------------------
module fact_cordic import fact_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       en_i,
  input  logic       valid_i,
  input  fact_cord_t cord_i,
  input  fact_tag_t  tag_i,
  output logic       valid_o,
  output fact_cord_t cord_o,
  output fact_tag_t  tag_o
);

  logic       valid_q [CORDIC_STEPS];
  fact_cord_t cord_q  [CORDIC_STEPS];
  fact_tag_t  tag_q   [CORDIC_STEPS];

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_stage
    logic                 vin;
    fact_cord_t           cin;
    fact_tag_t            tin;
    fact_cord_t           cord_d;
    logic signed [CW-1:0] xv, yv, xs, ys;
    logic signed [ZW-1:0] zv, ang;
    logic                 dpos;

    if (i == 0) begin : g_first
      assign vin = valid_i;
      assign cin = cord_i;
      assign tin = tag_i;
    end else begin : g_rest
      assign vin = valid_q[i-1];
      assign cin = cord_q[i-1];
      assign tin = tag_q[i-1];
    end

    assign xv   = cin.x;
    assign yv   = cin.y;
    assign zv   = cin.z;
    assign xs   = xv >>> i;
    assign ys   = yv >>> i;
    assign ang  = $signed({{(ZW-32){1'b0}}, ATAN_Q32[i]});
    // rotation follows the residual angle, vectoring drives y towards zero
    assign dpos = cin.rot ? (zv >= 0) : (yv < 0);

    always_comb begin
      cord_d     = cin;
      if (dpos) begin
        cord_d.x = xv - ys;
        cord_d.y = yv + xs;
        cord_d.z = zv - ang;
      end else begin
        cord_d.x = xv + ys;
        cord_d.y = yv - xs;
        cord_d.z = zv + ang;
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[i] <= 1'b0;
      end else if (en_i) begin
        valid_q[i] <= vin;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        cord_q[i] <= cord_d;
        tag_q[i]  <= tin;
      end
    end
  end

  assign valid_o = valid_q[CORDIC_STEPS-1];
  assign cord_o  = cord_q[CORDIC_STEPS-1];
  assign tag_o   = tag_q[CORDIC_STEPS-1];

endmodule

>>> src/fact_div.sv
// ----------------------------------------------------------------------------
// fact_div
// Pipelined restoring divider, one quotient bit per stage. Beats marked
// bypass pass through untouched.
// ----------------------------------------------------------------------------
module fact_div import fact_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      en_i,
  input  logic      valid_i,
  input  fact_div_t div_i,
  output logic      valid_o,
  output fact_div_t div_o
);

  logic      valid_q [QBITS];
  fact_div_t div_q   [QBITS];

  for (genvar i = 0; i < QBITS; i++) begin : g_stage
    logic        vin;
    fact_div_t   din;
    fact_div_t   div_d;
    logic [64:0] trial;
    logic [64:0] diff;
    logic        ge;

    if (i == 0) begin : g_first
      assign vin = valid_i;
      assign din = div_i;
    end else begin : g_rest
      assign vin = valid_q[i-1];
      assign din = div_q[i-1];
    end

    // remainder stays below den, so the trial fits in 65 bits
    assign trial = {din.rem, din.low[QBITS-1]};
    assign diff  = trial - {1'b0, din.den};
    assign ge    = trial >= {1'b0, din.den};

    always_comb begin
      div_d       = din;
      if (!din.bypass) begin
        div_d.low = {din.low[QBITS-2:0], 1'b0};
        div_d.quo = {din.quo[QBITS-2:0], ge};
        div_d.rem = ge ? diff[63:0] : trial[63:0];
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[i] <= 1'b0;
      end else if (en_i) begin
        valid_q[i] <= vin;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        div_q[i] <= div_d;
      end
    end
  end

  assign valid_o = valid_q[QBITS-1];
  assign div_o   = div_q[QBITS-1];

endmodule

>>> src/fact_checker.sv
// ----------------------------------------------------------------------------
// fact_checker
// Port-level checks on the coordinate transform: stall cause, result hold
// and saturation on error.
// ----------------------------------------------------------------------------
module fact_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic signed [31:0] converted_o,
  input logic        range_error_o
);

  // the input side only waits on a blocked result
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without a blocked result");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=>
      out_valid_o && $stable(converted_o) && $stable(range_error_o))
    else $error("stalled result beat changed");

  // a raised error always comes with a saturated value
  a_err_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && range_error_o |->
      converted_o == 32'sh7FFFFFFF || converted_o == 32'sh80000000)
    else $error("range error without saturation");

endmodule

bind field_aligned_coord_transform fact_checker u_fact_checker (.*);
